### design/ovs_pkg.sv
// Package for the obstacle velocity shaper: widths, codes, cosine ROM builder
// and the small arithmetic helpers of the pipeline.
// Depends on nothing; used by obstacle_velocity_shaper.
package ovs_pkg;

	localparam int COS_TABLE_BITS = 10;
	localparam int COS_N = 1 << COS_TABLE_BITS;
	localparam int KW = COS_TABLE_BITS + 1;
	localparam int XW = 14 + COS_TABLE_BITS;
	localparam int RECIP_SHIFT = 40;
	localparam int RW = 27;
	localparam int PW = XW + RW;
	localparam logic [13:0] PI_Q12 = 14'd12868;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << RECIP_SHIFT) / 64'd12868);
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ONE_Q30 = 64'd1073741824;
	localparam int DIV_STAGES = 17;

	typedef enum logic [1:0] {
		ZONE_CLEAR   = 2'd0,
		ZONE_CAUTION = 2'd1,
		ZONE_DANGER  = 2'd2
	} zone_t;

	typedef enum logic [2:0] {
		REG_SAFE_DIST    = 3'd0,
		REG_DANGER_DIST  = 3'd1,
		REG_LIN_GAIN     = 3'd2,
		REG_ANG_GAIN     = 3'd3,
		REG_LIN_LIMIT    = 3'd4,
		REG_LIN_DEADBAND = 3'd5,
		REG_ANG_LIMIT    = 3'd6,
		REG_ANG_DEADBAND = 3'd7
	} reg_idx_t;

	typedef logic signed [15:0] cos_rom_t [0:COS_N];

	typedef struct packed {
		zone_t              zone;
		logic               neg;
		logic               csign;
		logic [15:0]        distance;
		logic signed [15:0] cl;
		logic signed [15:0] ca;
	} ctx_t;

	typedef struct packed {
		logic        zero;
		logic        sat;
		logic [20:0] rem;
		logic [16:0] num_lo;
		logic [16:0] quo;
	} div_t;

	// Cosine of k*pi/N in Q1.14, evaluated with a Q30 power series.
	function automatic cos_rom_t build_cos_rom();
		cos_rom_t rom;
		int k;
		int i;
		int kk;
		logic flip;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint sum;
		logic [63:0] r;
		for (k = 0; k <= COS_N; k++) begin
			kk = k;
			flip = 1'b0;
			if (2 * kk > COS_N) begin
				kk = COS_N - kk;
				flip = 1'b1;
			end
			x = (64'(kk) * PI_Q30) >> COS_TABLE_BITS;
			x2 = (x * x) >> 30;
			term = ONE_Q30;
			sum = longint'(ONE_Q30);
			for (i = 1; i <= 10; i++) begin
				term = ((term * x2) >> 30) / 64'((2 * i - 1) * (2 * i));
				if (i[0]) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			r = (64'(sum) + 64'd32768) >> 16;
			rom[k] = flip ? -$signed(r[15:0]) : $signed(r[15:0]);
		end
		return rom;
	endfunction

	// One restoring step: one quotient bit, divisor is 16 times the distance.
	function automatic div_t div_step(div_t s, logic [15:0] d);
		div_t o;
		logic [20:0] r2;
		logic [20:0] den;
		o = s;
		den = {1'b0, d, 4'b0};
		r2 = {s.rem[19:0], s.num_lo[16]};
		if (r2 >= den) begin
			o.rem = r2 - den;
			o.quo = {s.quo[15:0], 1'b1};
		end else begin
			o.rem = r2;
			o.quo = {s.quo[15:0], 1'b0};
		end
		o.num_lo = {s.num_lo[15:0], 1'b0};
		return o;
	endfunction

	// Signed repulsion term; a saturated quotient stands for any value past every limit.
	function automatic logic signed [19:0] term_value(div_t s, logic negate);
		logic [17:0] mag;
		logic signed [19:0] t;
		if (s.zero) mag = 18'd0;
		else if (s.sat) mag = 18'h20000;
		else mag = {1'b0, s.quo};
		t = $signed({2'b0, mag});
		return negate ? -t : t;
	endfunction

	function automatic logic signed [15:0] shape(logic signed [19:0] v, logic [14:0] lim,
			logic [14:0] db);
		logic signed [19:0] l;
		logic signed [19:0] t;
		logic signed [19:0] m;
		l = $signed({5'b0, lim});
		t = v;
		if (t > l) t = l;
		else if (t < -l) t = -l;
		m = (t < 0) ? -t : t;
		if (m < $signed({5'b0, db})) t = '0;
		return t[15:0];
	endfunction

endpackage

### design/obstacle_velocity_shaper.sv
// Top level of the obstacle velocity shaper: configuration registers and the
// full shaping pipeline. Depends on ovs_pkg.
//
// The shaper takes one sample per clock while the output side is not held, and
// returns one result per sample, in order. The bulk of the pipeline is the
// seventeen restoring divider stages that form the repulsion term
// gain*cos/(16*distance) for both axes in parallel; ahead of them sit the bearing
// fold, a reciprocal multiply for the cosine index, the registered cosine ROM
// read and the gain multiply, and behind them one stage that selects the zone
// result, clamps and applies the deadband. The whole pipeline moves as
// one: while a finished result waits for out_ready, every stage holds, and a
// new input transfer is taken whenever the output register is empty or is being
// drained in the same cycle. Configuration writes take effect at once and must
// only be made while no sample is in flight.
module obstacle_velocity_shaper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [15:0]         obstacle_distance,
	input  logic signed [14:0]  obstacle_bearing,
	input  logic signed [15:0]  command_linear,
	input  logic signed [15:0]  command_angular,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  drive_linear,
	output logic signed [15:0]  drive_angular,
	output logic [1:0]          zone,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	localparam ovs_pkg::cos_rom_t COS_ROM = ovs_pkg::build_cos_rom();

	// Configuration registers.
	logic [15:0] safe_q;
	logic [15:0] danger_q;
	logic [14:0] lin_gain_q;
	logic [14:0] ang_gain_q;
	logic [14:0] lin_limit_q;
	logic [14:0] lin_db_q;
	logic [14:0] ang_limit_q;
	logic [14:0] ang_db_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			safe_q      <= 16'd512;
			danger_q    <= 16'd205;
			lin_gain_q  <= 15'd819;
			ang_gain_q  <= 15'd1229;
			lin_limit_q <= 15'd6144;
			lin_db_q    <= 15'd205;
			ang_limit_q <= 15'd6144;
			ang_db_q    <= 15'd205;
		end else if (cfg_write) begin
			unique case (ovs_pkg::reg_idx_t'(cfg_index))
				ovs_pkg::REG_SAFE_DIST:    safe_q      <= cfg_data;
				ovs_pkg::REG_DANGER_DIST:  danger_q    <= cfg_data;
				ovs_pkg::REG_LIN_GAIN:     lin_gain_q  <= cfg_data[14:0];
				ovs_pkg::REG_ANG_GAIN:     ang_gain_q  <= cfg_data[14:0];
				ovs_pkg::REG_LIN_LIMIT:    lin_limit_q <= cfg_data[14:0];
				ovs_pkg::REG_LIN_DEADBAND: lin_db_q    <= cfg_data[14:0];
				ovs_pkg::REG_ANG_LIMIT:    ang_limit_q <= cfg_data[14:0];
				ovs_pkg::REG_ANG_DEADBAND: ang_db_q    <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// All stages advance together whenever the output register can take a value.
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: fold the bearing, take its magnitude, classify the distance.
	logic signed [16:0] bear_ext;
	logic signed [16:0] fold;
	logic [13:0] fold_mag;
	ovs_pkg::zone_t zone_in;

	always_comb begin
		bear_ext = 17'(obstacle_bearing);
		if (bear_ext > 17'sd0) fold = $signed({3'b0, ovs_pkg::PI_Q12}) - bear_ext;
		else fold = -(bear_ext + $signed({3'b0, ovs_pkg::PI_Q12}));
		fold_mag = fold[16] ? 14'(-fold) : fold[13:0];
		if (obstacle_distance < safe_q && obstacle_distance > danger_q)
			zone_in = ovs_pkg::ZONE_CAUTION;
		else if (obstacle_distance < danger_q) zone_in = ovs_pkg::ZONE_DANGER;
		else zone_in = ovs_pkg::ZONE_CLEAR;
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	ovs_pkg::ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	logic [ovs_pkg::XW-1:0] x_s1, x_s2;
	logic [ovs_pkg::KW-1:0] q0_s2, k_s3;
	logic signed [15:0] cos_s4;
	logic [29:0] plin_s5, pang_s5;
	ovs_pkg::div_t lin_s6, ang_s6;

	logic [ovs_pkg::PW-1:0] recip_prod;
	logic [ovs_pkg::XW-1:0] rem_est;
	logic [ovs_pkg::KW-1:0] k_next;
	logic [14:0] cos_mag;
	ovs_pkg::ctx_t ctx_sign;
	logic [29:0] num_lin, num_ang;
	logic [36:0] sat_bound;

	always_comb begin
		recip_prod = ovs_pkg::PW'(x_s1) * ovs_pkg::PW'(ovs_pkg::RECIP);
		// The reciprocal estimate is exact or one short; one compare fixes it.
		rem_est = x_s2 - ovs_pkg::XW'(q0_s2) * ovs_pkg::XW'(ovs_pkg::PI_Q12);
		k_next = (rem_est >= ovs_pkg::XW'(ovs_pkg::PI_Q12)) ? q0_s2 + 1'b1 : q0_s2;
		if (k_next > ovs_pkg::KW'(ovs_pkg::COS_N)) k_next = ovs_pkg::KW'(ovs_pkg::COS_N);
		cos_mag = cos_s4[15] ? 15'(-cos_s4) : cos_s4[14:0];
		// The cosine sign joins the context here.
		ctx_sign = ctx_s4;
		ctx_sign.csign = cos_s4[15];
		num_lin = plin_s5 + 30'({ctx_s5.distance, 3'b0});
		num_ang = pang_s5 + 30'({ctx_s5.distance, 3'b0});
		sat_bound = {ctx_s5.distance, 21'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1.zone     <= zone_in;
			ctx_s1.neg      <= fold[16];
			ctx_s1.csign    <= 1'b0;
			ctx_s1.distance <= obstacle_distance;
			ctx_s1.cl       <= command_linear;
			ctx_s1.ca       <= command_angular;
			x_s1 <= {fold_mag, {ovs_pkg::COS_TABLE_BITS{1'b0}}}
				+ ovs_pkg::XW'(ovs_pkg::PI_Q12 >> 1);

			ctx_s2 <= ctx_s1;
			x_s2 <= x_s1;
			q0_s2 <= recip_prod[ovs_pkg::RECIP_SHIFT +: ovs_pkg::KW];

			ctx_s3 <= ctx_s2;
			k_s3 <= k_next;

			ctx_s4 <= ctx_s3;
			cos_s4 <= COS_ROM[k_s3];

			ctx_s5 <= ctx_sign;
			plin_s5 <= 30'(lin_gain_q) * 30'(cos_mag);
			pang_s5 <= 30'(ang_gain_q) * 30'(cos_mag);

			ctx_s6 <= ctx_s5;
			lin_s6.zero   <= (plin_s5 == 30'd0);
			lin_s6.sat    <= {7'b0, num_lin} >= sat_bound;
			lin_s6.rem    <= 21'(num_lin[29:17]);
			lin_s6.num_lo <= num_lin[16:0];
			lin_s6.quo    <= '0;
			ang_s6.zero   <= (pang_s5 == 30'd0);
			ang_s6.sat    <= {7'b0, num_ang} >= sat_bound;
			ang_s6.rem    <= 21'(num_ang[29:17]);
			ang_s6.num_lo <= num_ang[16:0];
			ang_s6.quo    <= '0;
		end
	end

	// Divider stages: one quotient bit per stage for each axis.
	logic          v_sd   [ovs_pkg::DIV_STAGES];
	ovs_pkg::ctx_t ctx_sd [ovs_pkg::DIV_STAGES];
	ovs_pkg::div_t lin_sd [ovs_pkg::DIV_STAGES];
	ovs_pkg::div_t ang_sd [ovs_pkg::DIV_STAGES];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_sd[0] <= ctx_s6;
			lin_sd[0] <= ovs_pkg::div_step(lin_s6, ctx_s6.distance);
			ang_sd[0] <= ovs_pkg::div_step(ang_s6, ctx_s6.distance);
			for (int j = 1; j < ovs_pkg::DIV_STAGES; j++) begin
				ctx_sd[j] <= ctx_sd[j-1];
				lin_sd[j] <= ovs_pkg::div_step(lin_sd[j-1], ctx_sd[j-1].distance);
				ang_sd[j] <= ovs_pkg::div_step(ang_sd[j-1], ctx_sd[j-1].distance);
			end
		end
	end

	// Final stage: pick the zone result, clamp and apply the deadband.
	ovs_pkg::ctx_t ctx_f;
	logic signed [19:0] term_lin, term_ang, val_lin, val_ang;

	always_comb begin
		ctx_f = ctx_sd[ovs_pkg::DIV_STAGES-1];
		term_lin = ovs_pkg::term_value(lin_sd[ovs_pkg::DIV_STAGES-1], ctx_f.csign);
		term_ang = ovs_pkg::term_value(ang_sd[ovs_pkg::DIV_STAGES-1],
			ctx_f.csign ^ ctx_f.neg);
		case (ctx_f.zone)
			ovs_pkg::ZONE_CAUTION: begin
				val_lin = 20'(ctx_f.cl) - term_lin;
				val_ang = 20'(ctx_f.ca) + term_ang;
			end
			ovs_pkg::ZONE_DANGER: begin
				val_lin = -term_lin;
				val_ang = term_ang;
			end
			default: begin
				val_lin = 20'(ctx_f.cl);
				val_ang = 20'(ctx_f.ca);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drive_linear  <= ovs_pkg::shape(val_lin, lin_limit_q, lin_db_q);
			drive_angular <= ovs_pkg::shape(val_ang, ang_limit_q, ang_db_q);
			zone          <= ctx_f.zone;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int j = 0; j < ovs_pkg::DIV_STAGES; j++) v_sd[j] <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_sd[0] <= v_s6;
			for (int j = 1; j < ovs_pkg::DIV_STAGES; j++) v_sd[j] <= v_sd[j-1];
			out_valid <= v_sd[ovs_pkg::DIV_STAGES-1];
		end
	end

endmodule

### tb/testbench.sv
// Self-checking testbench for obstacle_velocity_shaper: a directed table, then random
// samples under several idling phases; results checked against typed rows or a local predictor.
// Depends on ovs_pkg and the obstacle_velocity_shaper RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PI_FIX = 12868;
	localparam int TABLE_N = 1 << 10;
	localparam int PIPE_LATENCY = 24;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [15:0] obstacle_distance = '0;
	logic signed [14:0] obstacle_bearing = '0;
	logic signed [15:0] command_linear = '0;
	logic signed [15:0] command_angular = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] drive_linear;
	logic signed [15:0] drive_angular;
	logic [1:0] zone;
	logic cfg_write = 1'b0;
	ovs_pkg::reg_idx_t cfg_index = ovs_pkg::REG_SAFE_DIST;
	logic [15:0] cfg_data = '0;

	obstacle_velocity_shaper u_top (.*);

	// Clock: 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	typedef struct {
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		ovs_pkg::zone_t z;
		logic known;
	} drive_t;

	typedef struct {
		logic [15:0] d;
		logic signed [14:0] b;
		logic signed [15:0] cl;
		logic signed [15:0] ca;
		logic signed [15:0] want_lin;
		logic signed [15:0] want_ang;
		ovs_pkg::zone_t want_zone;
		logic typed;
	} sample_row_t;

	// The predictor keeps its own copy of the register file.
	logic [15:0] shadow_regs [0:7];
	int cos_values [0:TABLE_N];
	drive_t expected_drives [$];
	int failures = 0;
	int idle_pct_in = 0;
	int idle_pct_out = 0;

	// Cosine table in Q1.14 from a Q30 power series, odd-symmetric about pi/2.
	function automatic int cos_q14(int k);
		longint unsigned x, x2, term;
		longint total;
		logic flip;
		int kk;
		int i;
		kk = k;
		flip = 1'b0;
		if (2 * kk > TABLE_N) begin
			kk = TABLE_N - kk;
			flip = 1'b1;
		end
		x = (longint'(kk) * 64'd3373259426) >> 10;
		x2 = (x * x) >> 30;
		term = 64'd1073741824;
		total = 64'sd1073741824;
		for (i = 1; i <= 10; i++) begin
			term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
			if (i % 2 == 1) total -= longint'(term);
			else total += longint'(term);
		end
		if (total < 0) total = 0;
		return flip ? -int'((total + 32768) >>> 16) : int'((total + 32768) >>> 16);
	endfunction

	function automatic longint repulsion(longint gain, int c, longint d, bit negate);
		longint p, m;
		p = gain * (c < 0 ? -c : c);
		if (p == 0) return 0;
		m = (d == 0) ? (64'sd1 <<< 31) : (p + 8 * d) / (16 * d);
		return ((c < 0) != negate) ? -m : m;
	endfunction

	function automatic longint clamp_deadband(longint v, longint lim, longint db);
		if (v > lim) v = lim;
		else if (v < -lim) v = -lim;
		if ((v < 0 ? -v : v) < db) v = 0;
		return v;
	endfunction

	function automatic drive_t predict_drive(logic [15:0] d, logic signed [14:0] b,
			logic signed [15:0] cl, logic signed [15:0] ca);
		drive_t r;
		int folded, k, c;
		longint tl, ta, vl, va;
		folded = (b > 0) ? PI_FIX - int'(b) : -(int'(b) + PI_FIX);
		k = ((folded < 0 ? -folded : folded) * TABLE_N + PI_FIX / 2) / PI_FIX;
		if (k > TABLE_N) k = TABLE_N;
		c = cos_values[k];
		tl = repulsion(shadow_regs[ovs_pkg::REG_LIN_GAIN], c, d, 1'b0);
		ta = repulsion(shadow_regs[ovs_pkg::REG_ANG_GAIN], c, d, folded < 0);
		if (d < shadow_regs[ovs_pkg::REG_SAFE_DIST]
				&& d > shadow_regs[ovs_pkg::REG_DANGER_DIST]) begin
			r.z = ovs_pkg::ZONE_CAUTION;
			vl = cl - tl;
			va = ca + ta;
		end else if (d < shadow_regs[ovs_pkg::REG_DANGER_DIST]) begin
			r.z = ovs_pkg::ZONE_DANGER;
			vl = -tl;
			va = ta;
		end else begin
			r.z = ovs_pkg::ZONE_CLEAR;
			vl = cl;
			va = ca;
		end
		r.lin = 16'(clamp_deadband(vl, shadow_regs[ovs_pkg::REG_LIN_LIMIT],
			shadow_regs[ovs_pkg::REG_LIN_DEADBAND]));
		r.ang = 16'(clamp_deadband(va, shadow_regs[ovs_pkg::REG_ANG_LIMIT],
			shadow_regs[ovs_pkg::REG_ANG_DEADBAND]));
		r.known = 1'b1;
		return r;
	endfunction

	// Registers are only written here, after every pending result has come back.
	task automatic write_reg(ovs_pkg::reg_idx_t idx, logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		shadow_regs[idx] = (idx <= ovs_pkg::REG_DANGER_DIST) ? value : {1'b0, value[14:0]};
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain_pipeline();
		in_valid <= 1'b0;
		while (expected_drives.size() != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	// Drives one sample; valid stays high until the transfer, payload held.
	// Valid drops only when the sender idles or the stream is drained.
	task automatic send_sample(logic [15:0] d, logic signed [14:0] b,
			logic signed [15:0] cl, logic signed [15:0] ca, drive_t typed);
		drive_t want;
		while ($urandom_range(99) < idle_pct_in) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		obstacle_distance <= d;
		obstacle_bearing <= b;
		command_linear <= cl;
		command_angular <= ca;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		want = typed.known ? typed : predict_drive(d, b, cl, ca);
		expected_drives.push_back(want);
		@(negedge clk);
	endtask

	// The output side: random stalls, and every transfer compared with the oldest expectation.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= idle_pct_out);
	end

	always @(posedge clk) begin
		drive_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_drives.size() == 0) begin
				$error("result transfer with nothing expected");
				failures++;
			end else begin
				want = expected_drives.pop_front();
				if (drive_linear !== want.lin) begin
					$error("drive_linear expected %0d got %0d", want.lin, drive_linear);
					failures++;
				end
				if (drive_angular !== want.ang) begin
					$error("drive_angular expected %0d got %0d", want.ang, drive_angular);
					failures++;
				end
				if (zone !== want.z) begin
					$error("zone expected %0d got %0d", want.z, zone);
					failures++;
				end
			end
		end
	end

	// Random sample: distances mostly near the bands, with some full-range values.
	task automatic send_random();
		logic [15:0] d;
		drive_t none;
		none.known = 1'b0;
		case ($urandom_range(3))
			0: d = 16'($urandom_range(65535));
			1: d = 16'($urandom_range(2 * int'(shadow_regs[ovs_pkg::REG_SAFE_DIST]) + 4));
			2: d = shadow_regs[$urandom_range(1)] + 16'($urandom_range(2)) - 16'd1;
			default: d = 16'($urandom_range(1023));
		endcase
		send_sample(d, 15'($urandom), 16'($urandom), 16'($urandom), none);
	endtask

	initial begin
		sample_row_t rows [$];
		drive_t typed;
		int i, phase;
		for (i = 0; i <= TABLE_N; i++) cos_values[i] = cos_q14(i);
		shadow_regs = '{16'd512, 16'd205, 16'd819, 16'd1229, 16'd6144, 16'd205,
			16'd6144, 16'd205};

		// Directed rows; the typed expectations are at the reset settings.
		rows = '{
			// Clear zone pass-through, and the clamp at both signs.
			'{16'd600, 15'sd0, 16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000,
				ovs_pkg::ZONE_CLEAR, 1},
			'{16'd65535, 15'sd5, 16'sh7fff, 16'sh8000, 16'sd6144, -16'sd6144,
				ovs_pkg::ZONE_CLEAR, 1},
			// Below the deadband both axes are zero.
			'{16'd512, 15'sd0, 16'sd204, -16'sd204, 16'sd0, 16'sd0, ovs_pkg::ZONE_CLEAR, 1},
			// Distance equal to danger is clear.
			'{16'd205, 15'sd100, 16'sd300, 16'sd300, 16'sd300, 16'sd300,
				ovs_pkg::ZONE_CLEAR, 1},
			// Zero distance saturates the terms to the limits.
			'{16'd0, 15'sd0, 16'sd0, 16'sd0, 16'sd6144, 16'sd6144, ovs_pkg::ZONE_DANGER, 1},
			'{16'd0, 15'sh4000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ovs_pkg::ZONE_DANGER, 0},
			'{16'd1, 15'sd12868, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ovs_pkg::ZONE_DANGER, 0},
			'{16'd206, 15'sh3fff, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ovs_pkg::ZONE_CAUTION, 0},
			'{16'd511, -15'sd12868, 16'sh7fff, 16'sh8000, 16'sd0, 16'sd0,
				ovs_pkg::ZONE_CAUTION, 0},
			'{16'd300, 15'sd6434, 16'sd100, 16'sd100, 16'sd0, 16'sd0, ovs_pkg::ZONE_CAUTION, 0},
			'{16'd300, -15'sd6434, -16'sd100, 16'sd0, 16'sd0, 16'sd0,
				ovs_pkg::ZONE_CAUTION, 0},
			'{16'd100, 15'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ovs_pkg::ZONE_DANGER, 0},
			'{16'd100, -15'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, ovs_pkg::ZONE_DANGER, 0},
			'{16'd204, 15'sd3000, 16'sd1, 16'sd1, 16'sd0, 16'sd0, ovs_pkg::ZONE_DANGER, 0}
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[r]) begin
			typed.lin = rows[r].want_lin;
			typed.ang = rows[r].want_ang;
			typed.z = rows[r].want_zone;
			typed.known = rows[r].typed;
			send_sample(rows[r].d, rows[r].b, rows[r].cl, rows[r].ca, typed);
		end
		drain_pipeline();

		// Settings per phase, extremes included; each phase also sets the idling mix.
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					idle_pct_in = 0;
					idle_pct_out = 0;
				end
				1: begin
					write_reg(ovs_pkg::REG_LIN_GAIN, 16'h7fff);
					write_reg(ovs_pkg::REG_ANG_GAIN, 16'h7fff);
					write_reg(ovs_pkg::REG_LIN_LIMIT, 16'h7fff);
					write_reg(ovs_pkg::REG_ANG_LIMIT, 16'h7fff);
					write_reg(ovs_pkg::REG_LIN_DEADBAND, 16'd0);
					write_reg(ovs_pkg::REG_ANG_DEADBAND, 16'd0);
					idle_pct_in = 57;
				end
				2: begin
					// Safe at or below danger leaves no caution band.
					write_reg(ovs_pkg::REG_SAFE_DIST, 16'd100);
					write_reg(ovs_pkg::REG_DANGER_DIST, 16'hffff);
					write_reg(ovs_pkg::REG_LIN_GAIN, 16'd0);
					idle_pct_in = 0;
					idle_pct_out = 57;
				end
				3: begin
					// Deadband above limit forces both axes to zero.
					write_reg(ovs_pkg::REG_SAFE_DIST, 16'hffff);
					write_reg(ovs_pkg::REG_DANGER_DIST, 16'd0);
					write_reg(ovs_pkg::REG_LIN_LIMIT, 16'd100);
					write_reg(ovs_pkg::REG_LIN_DEADBAND, 16'h7fff);
					write_reg(ovs_pkg::REG_ANG_LIMIT, 16'd0);
					write_reg(ovs_pkg::REG_ANG_DEADBAND, 16'd50);
					idle_pct_in = 19;
					idle_pct_out = 19;
				end
				default: begin
					write_reg(ovs_pkg::REG_SAFE_DIST, 16'($urandom_range(2047)));
					write_reg(ovs_pkg::REG_DANGER_DIST, 16'($urandom_range(1023)));
					write_reg(ovs_pkg::REG_LIN_GAIN, 16'($urandom_range(32767)));
					write_reg(ovs_pkg::REG_ANG_GAIN, 16'($urandom_range(32767)));
					write_reg(ovs_pkg::REG_LIN_LIMIT, 16'($urandom_range(32767)));
					write_reg(ovs_pkg::REG_LIN_DEADBAND, 16'($urandom_range(1000)));
					write_reg(ovs_pkg::REG_ANG_LIMIT, 16'($urandom_range(32767)));
					write_reg(ovs_pkg::REG_ANG_DEADBAND, 16'($urandom_range(1000)));
					idle_pct_in = (phase % 2) ? 57 : 0;
					idle_pct_out = (phase >= 6) ? 57 : 0;
				end
			endcase
			repeat (160) send_random();
			drain_pipeline();
		end

		if (failures == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	// Watchdog, far beyond the slowest legitimate run.
	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Left-over expectations at the end are caught by the drain wait timing out.
endmodule

### sim.f
design/ovs_pkg.sv
design/obstacle_velocity_shaper.sv
tb/testbench.sv
